// ===== rtl/mwia_pkg.sv =====
// Shared types, opcodes and helpers for the multi-width integer ALU.
// Used by every module under rtl/; depends on nothing.
package mwia_pkg;

   localparam int WORD = 64;
   localparam int DIV_STAGES = WORD;

   // Opcodes
   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_SUB = 4'd1;
   localparam logic [3:0] OP_MUL = 4'd2;
   localparam logic [3:0] OP_DIV = 4'd3;
   localparam logic [3:0] OP_MOD = 4'd4;
   localparam logic [3:0] OP_AND = 4'd5;
   localparam logic [3:0] OP_OR  = 4'd6;
   localparam logic [3:0] OP_SHL = 4'd7;
   localparam logic [3:0] OP_SHR = 4'd8;

   // Register indexes
   localparam logic [7:0] REG_SIGNED_MODE  = 8'd0;
   localparam logic [7:0] REG_WIDTH_SELECT = 8'd1;

   // Width select codes
   localparam logic [1:0] WSEL_8  = 2'd0;
   localparam logic [1:0] WSEL_16 = 2'd1;
   localparam logic [1:0] WSEL_32 = 2'd2;
   localparam logic [1:0] WSEL_64 = 2'd3;

   // Operands after masking and sign extension
   typedef struct packed {
      logic [3:0]      op;
      logic [1:0]      wsel;
      logic [WORD-1:0] am;
      logic [WORD-1:0] bm;
      logic [WORD-1:0] ax;
      logic [WORD-1:0] bx;
      logic            an;
      logic            bn;
      logic [WORD-1:0] mag_a;
      logic [WORD-1:0] mag_b;
   } prep_type;

   // What rides alongside the divider
   typedef struct packed {
      logic [3:0]      op;
      logic [1:0]      wsel;
      logic            an;
      logic            bn;
      logic            bzero;
      logic [WORD-1:0] res;
   } side_type;

   function automatic logic [WORD-1:0] width_mask(input logic [1:0] wsel);
      logic [WORD-1:0] m;
      unique case (wsel)
         WSEL_8:  m = {{(WORD-8){1'b0}}, {8{1'b1}}};
         WSEL_16: m = {{(WORD-16){1'b0}}, {16{1'b1}}};
         WSEL_32: m = {{(WORD-32){1'b0}}, {32{1'b1}}};
         default: m = {WORD{1'b1}};
      endcase
      return m;
   endfunction

   function automatic logic [6:0] width_bits(input logic [1:0] wsel);
      logic [6:0] w;
      unique case (wsel)
         WSEL_8:  w = 7'd8;
         WSEL_16: w = 7'd16;
         WSEL_32: w = 7'd32;
         default: w = 7'd64;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/mwia_prep.sv =====
// Stage 1: masks operands to the width, sign-extends and forms magnitudes.
// Depends on mwia_pkg.
module mwia_prep (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [3:0]                opcode,
   input  logic [mwia_pkg::WORD-1:0] operand_a,
   input  logic [mwia_pkg::WORD-1:0] operand_b,
   input  logic                      signed_mode,
   input  logic [1:0]                width_select,
   output logic                      out_valid,
   output mwia_pkg::prep_type        out_data
);

   logic                      valid_ff;
   mwia_pkg::prep_type        data_ff, data_in;
   logic [mwia_pkg::WORD-1:0] mask;
   logic                      sa, sb;

   // Mask, sign-extend, take magnitudes
   always_comb begin
      mask = mwia_pkg::width_mask(width_select);
      data_in.op   = opcode;
      data_in.wsel = width_select;
      data_in.am   = operand_a & mask;
      data_in.bm   = operand_b & mask;
      unique case (width_select)
         mwia_pkg::WSEL_8: begin
            sa = data_in.am[7];
            sb = data_in.bm[7];
         end
         mwia_pkg::WSEL_16: begin
            sa = data_in.am[15];
            sb = data_in.bm[15];
         end
         mwia_pkg::WSEL_32: begin
            sa = data_in.am[31];
            sb = data_in.bm[31];
         end
         default: begin
            sa = data_in.am[63];
            sb = data_in.bm[63];
         end
      endcase
      data_in.an = signed_mode & sa;
      data_in.bn = signed_mode & sb;
      data_in.ax = data_in.an ? (data_in.am | ~mask) : data_in.am;
      data_in.bx = data_in.bn ? (data_in.bm | ~mask) : data_in.bm;
      data_in.mag_a = data_in.an ? (~data_in.ax + 1'b1) : data_in.ax;
      data_in.mag_b = data_in.bn ? (~data_in.bx + 1'b1) : data_in.bx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/mwia_exec.sv =====
// Stages 2 and 3: add/sub/logic/shift results and the split 64-bit multiply.
// Depends on mwia_pkg.
module mwia_exec (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  mwia_pkg::prep_type        in_data,
   output logic                      out_valid,
   output mwia_pkg::side_type        out_side,
   output logic [mwia_pkg::WORD-1:0] out_mag_a,
   output logic [mwia_pkg::WORD-1:0] out_mag_b
);

   localparam int HALF = mwia_pkg::WORD / 2;

   logic                      s2_valid_ff, s3_valid_ff;
   mwia_pkg::side_type        s2_side_ff, s2_side_in, s3_side_ff, s3_side_in;
   logic [mwia_pkg::WORD-1:0] s2_mag_a_ff, s2_mag_b_ff, s3_mag_a_ff, s3_mag_b_ff;
   logic [mwia_pkg::WORD-1:0] p0_ff, p0_in;
   logic [HALF-1:0]           p1_ff, p1_in, p2_ff, p2_in;
   logic [mwia_pkg::WORD-1:0] prod1, prod2;
   logic                      over;
   logic [5:0]                sh;

   // Stage 2: add/sub/logic/shift results and multiply partial products
   always_comb begin
      over  = in_data.bm >= {{(mwia_pkg::WORD-7){1'b0}},
                             mwia_pkg::width_bits(in_data.wsel)};
      sh    = in_data.bm[5:0];
      p0_in = {{HALF{1'b0}}, in_data.ax[HALF-1:0]} * {{HALF{1'b0}}, in_data.bx[HALF-1:0]};
      prod1 = {{HALF{1'b0}}, in_data.ax[HALF-1:0]} * {{HALF{1'b0}}, in_data.bx[mwia_pkg::WORD-1:HALF]};
      prod2 = {{HALF{1'b0}}, in_data.ax[mwia_pkg::WORD-1:HALF]} * {{HALF{1'b0}}, in_data.bx[HALF-1:0]};
      p1_in = prod1[HALF-1:0];
      p2_in = prod2[HALF-1:0];
      s2_side_in.op    = in_data.op;
      s2_side_in.wsel  = in_data.wsel;
      s2_side_in.an    = in_data.an;
      s2_side_in.bn    = in_data.bn;
      s2_side_in.bzero = (in_data.mag_b == '0);
      unique case (in_data.op)
         mwia_pkg::OP_ADD: s2_side_in.res = in_data.ax + in_data.bx;
         mwia_pkg::OP_SUB: s2_side_in.res = in_data.ax - in_data.bx;
         mwia_pkg::OP_AND: s2_side_in.res = in_data.ax & in_data.bx;
         mwia_pkg::OP_OR:  s2_side_in.res = in_data.ax | in_data.bx;
         mwia_pkg::OP_SHL: s2_side_in.res = over ? '0 : (in_data.am << sh);
         mwia_pkg::OP_SHR: begin
            if (over) begin
               s2_side_in.res = in_data.an ? '1 : '0;
            end else if (in_data.an) begin
               s2_side_in.res = $unsigned($signed(in_data.ax) >>> sh);
            end else begin
               s2_side_in.res = in_data.ax >> sh;
            end
         end
         default: s2_side_in.res = '0;
      endcase
   end

   // Stage 3: sum the partial products
   always_comb begin
      s3_side_in = s2_side_ff;
      if (s2_side_ff.op == mwia_pkg::OP_MUL) begin
         s3_side_in.res = p0_ff + {p1_ff + p2_ff, {HALF{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= in_valid;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_side_ff  <= s2_side_in;
         p0_ff       <= p0_in;
         p1_ff       <= p1_in;
         p2_ff       <= p2_in;
         s2_mag_a_ff <= in_data.mag_a;
         s2_mag_b_ff <= in_data.mag_b;
         s3_side_ff  <= s3_side_in;
         s3_mag_a_ff <= s2_mag_a_ff;
         s3_mag_b_ff <= s2_mag_b_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_side  = s3_side_ff;
   assign out_mag_a = s3_mag_a_ff;
   assign out_mag_b = s3_mag_b_ff;

endmodule

// ===== rtl/mwia_div.sv =====
// Radix-2 restoring divider, one quotient bit per pipeline stage.
// Carries the side record of each item along. Depends on mwia_pkg.
module mwia_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  mwia_pkg::side_type        in_side,
   input  logic [mwia_pkg::WORD-1:0] in_dividend,
   input  logic [mwia_pkg::WORD-1:0] in_divisor,
   output logic                      out_valid,
   output mwia_pkg::side_type        out_side,
   output logic [mwia_pkg::WORD-1:0] out_quo,
   output logic [mwia_pkg::WORD-1:0] out_rem
);

   localparam int N = mwia_pkg::DIV_STAGES;
   localparam int W = mwia_pkg::WORD;

   logic               valid_w [0:N];
   mwia_pkg::side_type side_w  [0:N];
   logic [W-1:0]       rem_w   [0:N];
   logic [W-1:0]       dvd_w   [0:N];
   logic [W-1:0]       dsr_w   [0:N];

   assign valid_w[0] = in_valid;
   assign side_w[0]  = in_side;
   assign rem_w[0]   = '0;
   assign dvd_w[0]   = in_dividend;
   assign dsr_w[0]   = in_divisor;

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic               valid_ff;
      mwia_pkg::side_type side_ff;
      logic [W-1:0]       rem_ff, rem_in, dvd_ff, dvd_in, dsr_ff;
      logic [W:0]         trial, diff;
      logic               take;

      // Shift in the next dividend bit, subtract when it fits
      always_comb begin
         trial  = {rem_w[k], dvd_w[k][W-1]};
         diff   = trial - {1'b0, dsr_w[k]};
         take   = trial >= {1'b0, dsr_w[k]};
         rem_in = take ? diff[W-1:0] : trial[W-1:0];
         dvd_in = {dvd_w[k][W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= valid_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff <= side_w[k];
            rem_ff  <= rem_in;
            dvd_ff  <= dvd_in;
            dsr_ff  <= dsr_w[k];
         end
      end

      assign valid_w[k+1] = valid_ff;
      assign side_w[k+1]  = side_ff;
      assign rem_w[k+1]   = rem_ff;
      assign dvd_w[k+1]   = dvd_ff;
      assign dsr_w[k+1]   = dsr_ff;
   end

   assign out_valid = valid_w[N];
   assign out_side  = side_w[N];
   assign out_quo   = dvd_w[N];
   assign out_rem   = rem_w[N];

endmodule

// ===== rtl/multi_width_integer_alu.sv =====
// Multi-width integer ALU: one item (opcode, two 64-bit operands) gives one
// result masked to the configured width (8/16/32/64, signed or unsigned).
// Throughput is one item per cycle while not stalled; every item passes through
// the 64-stage radix-2 divider to keep results in order
// (1 prep stage, 2 execute/multiply stages, 64 divide stages, 1 output stage).
// The whole pipeline holds while a result waits with rsp_stall high.
// Configuration writes are always taken (csr_ready is tied high).
// Depends on mwia_pkg, mwia_prep, mwia_exec, mwia_div.
module multi_width_integer_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_opcode,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic                      signed_mode_ff;
   logic [1:0]                width_select_ff;
   logic                      adv;
   logic                      prep_valid, exec_valid, div_valid;
   mwia_pkg::prep_type        prep_data;
   mwia_pkg::side_type        exec_side, div_side;
   logic [mwia_pkg::WORD-1:0] exec_mag_a, exec_mag_b, div_quo, div_rem;
   logic                      rsp_valid_ff;
   logic [mwia_pkg::WORD-1:0] rsp_result_ff, rsp_result_in;

   // Pipeline moves unless a result is held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff  <= 1'b0;
         width_select_ff <= mwia_pkg::WSEL_64;
      end else if (csr_valid) begin
         if (csr_index == mwia_pkg::REG_SIGNED_MODE) begin
            signed_mode_ff <= csr_wdata[0];
         end else if (csr_index == mwia_pkg::REG_WIDTH_SELECT) begin
            width_select_ff <= csr_wdata[1:0];
         end
      end
   end

   mwia_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .en           (adv),
      .in_valid     (req_valid),
      .opcode       (req_opcode),
      .operand_a    (req_operand_a),
      .operand_b    (req_operand_b),
      .signed_mode  (signed_mode_ff),
      .width_select (width_select_ff),
      .out_valid    (prep_valid),
      .out_data     (prep_data)
   );

   mwia_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (prep_valid),
      .in_data   (prep_data),
      .out_valid (exec_valid),
      .out_side  (exec_side),
      .out_mag_a (exec_mag_a),
      .out_mag_b (exec_mag_b)
   );

   mwia_div u_div (
      .clock       (clock),
      .reset       (reset),
      .en          (adv),
      .in_valid    (exec_valid),
      .in_side     (exec_side),
      .in_dividend (exec_mag_a),
      .in_divisor  (exec_mag_b),
      .out_valid   (div_valid),
      .out_side    (div_side),
      .out_quo     (div_quo),
      .out_rem     (div_rem)
   );

   // Sign fix-up for divide/modulo, then mask to width
   always_comb begin
      unique case (div_side.op)
         mwia_pkg::OP_DIV: begin
            if (div_side.bzero) begin
               rsp_result_in = '0;
            end else begin
               rsp_result_in = (div_side.an ^ div_side.bn) ? (~div_quo + 1'b1) : div_quo;
            end
         end
         mwia_pkg::OP_MOD: begin
            if (div_side.bzero) begin
               rsp_result_in = '0;
            end else begin
               rsp_result_in = div_side.an ? (~div_rem + 1'b1) : div_rem;
            end
         end
         default: rsp_result_in = div_side.res;
      endcase
      rsp_result_in = rsp_result_in & mwia_pkg::width_mask(div_side.wsel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_ff;

`ifndef SYNTHESIS
   // A held result must hold the request side too
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while result held");

   // An accepted item shows up in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> prep_valid)
      else $error("accepted item lost at entry");

   // Divide or modulo by zero yields zero
   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      (div_valid && div_side.bzero &&
       (div_side.op == mwia_pkg::OP_DIV || div_side.op == mwia_pkg::OP_MOD))
      |-> (rsp_result_in == '0))
      else $error("divide by zero gave nonzero result");
`endif

endmodule

// ===== verif/multi_width_integer_alu_checker.sv =====
// Checker for the multi-width integer ALU: watches the request, response and
// register channels, predicts each result and compares. Depends on mwia_pkg.
`timescale 1ns / 1ps

module multi_width_integer_alu_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [3:0]  req_opcode,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_result_value,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   logic        signed_cfg;
   logic [1:0]  width_cfg;
   logic [63:0] expected_results[$];

   // Integer operation at the configured width, result masked to it.
   function automatic logic [63:0] alu_result(input logic [3:0] op,
         input logic [63:0] a, input logic [63:0] b,
         input logic sgn, input logic [1:0] wsel);
      logic [63:0] mask, sbit, am, bm, ax, bx, mag_a, mag_b, r;
      logic [7:0]  wbits;
      logic        an, bn;
      wbits = 8'd8 << wsel;
      mask  = (wsel == mwia_pkg::WSEL_64) ? {64{1'b1}} : ((64'd1 << wbits) - 64'd1);
      sbit  = (mask >> 1) + 64'd1;
      am    = a & mask;
      bm    = b & mask;
      ax    = (sgn && (am & sbit) != 0) ? (am | ~mask) : am;
      bx    = (sgn && (bm & sbit) != 0) ? (bm | ~mask) : bm;
      an    = sgn && ax[63];
      bn    = sgn && bx[63];
      mag_a = an ? -ax : ax;
      mag_b = bn ? -bx : bx;
      case (op)
         mwia_pkg::OP_ADD: r = ax + bx;
         mwia_pkg::OP_SUB: r = ax - bx;
         mwia_pkg::OP_MUL: r = ax * bx;
         mwia_pkg::OP_DIV: begin
            if (mag_b == 0) r = 0;
            else begin
               r = mag_a / mag_b;
               if (an != bn) r = -r;
            end
         end
         mwia_pkg::OP_MOD: begin
            if (mag_b == 0) r = 0;
            else begin
               r = mag_a % mag_b;
               if (an) r = -r;
            end
         end
         mwia_pkg::OP_AND: r = ax & bx;
         mwia_pkg::OP_OR:  r = ax | bx;
         mwia_pkg::OP_SHL: r = (bm >= wbits) ? 64'd0 : (am << bm[6:0]);
         mwia_pkg::OP_SHR: begin
            if (bm >= wbits) r = an ? {64{1'b1}} : 64'd0;
            else begin
               r = ax >> bm[6:0];
               // arithmetic fill from the sign bit
               if (an && bm != 0) r = r | ~({64{1'b1}} >> bm[6:0]);
            end
         end
         default: r = 0;
      endcase
      return r & mask;
   endfunction

   assign pending = expected_results.size();

   always @(posedge clock) begin
      if (reset) begin
         signed_cfg <= 1'b0;
         width_cfg  <= mwia_pkg::WSEL_64;
         fail_count <= 0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == mwia_pkg::REG_SIGNED_MODE) signed_cfg <= csr_wdata[0];
            else if (csr_index == mwia_pkg::REG_WIDTH_SELECT) width_cfg <= csr_wdata[1:0];
         end
         // compare each accepted result with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, actual %h", $time, rsp_result_value);
               fail_count <= fail_count + 1;
            end else if (expected_results[0] !== rsp_result_value) begin
               $display("%0t: result_value mismatch, expected %h actual %h",
                  $time, expected_results[0], rsp_result_value);
               fail_count <= fail_count + 1;
               void'(expected_results.pop_front());
            end else begin
               void'(expected_results.pop_front());
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(alu_result(req_opcode, req_operand_a,
               req_operand_b, signed_cfg, width_cfg));
      end
   end

endmodule

// ===== verif/multi_width_integer_alu_tb.sv =====
// Testbench top for the multi-width integer ALU: clock, reset, stimulus and
// verdict. Depends on mwia_pkg, the block and multi_width_integer_alu_checker.
`timescale 1ns / 1ps

module multi_width_integer_alu_tb;

   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [3:0]  req_opcode;
   logic [63:0] req_operand_a, req_operand_b;
   logic        rsp_valid, rsp_stall;
   logic [63:0] rsp_result_value;
   logic        csr_valid, csr_ready;
   logic [7:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count, pending;
   int          send_idle_pct, recv_idle_pct;
   int          cycle_count;
   logic        hold_request;

   multi_width_integer_alu DUT (.*);

   multi_width_integer_alu_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("multi_width_integer_alu test failed");
         $finish;
      end
   end

   // Response side: random stalls, plus one long hold-off on request
   int  hold_left;
   logic hold_done;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_item(input logic [3:0] op, input logic [63:0] a,
         input logic [63:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Wait until every predicted result is back, then let the pipe empty
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Upper register bits are junk on purpose; only the low bits count
   task automatic set_mode(input logic sgn, input logic [1:0] wsel);
      write_reg(mwia_pkg::REG_SIGNED_MODE, {$urandom} & 32'hFFFF_FFFE | sgn);
      write_reg(mwia_pkg::REG_WIDTH_SELECT, {$urandom} & 32'hFFFF_FFFC | wsel);
      csr_valid <= 1'b0;
   endtask

   // Operands biased toward the interesting corners
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(9))
         0: return 64'd0;
         1: return {64{1'b1}};
         2: return 64'd1;
         3: return 64'h80 << (8 * $urandom_range(7));
         4: return 64'h7F << (8 * $urandom_range(7)) | ((64'd1 << (8 * $urandom_range(7))) - 1);
         5: return {$urandom} & 64'hFF;
         6: return {56'd0, 8'($urandom_range(70))};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      int          cfg;
      logic [3:0]  op;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = '0;
      req_operand_a = '0;
      req_operand_b = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      cycle_count   = 0;
      hold_request  = 1'b0;
      send_idle_pct = 21;
      recv_idle_pct = 79;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: signed 8-bit corners
      set_mode(1'b1, mwia_pkg::WSEL_8);
      send_item(mwia_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FF7F, 64'h1);
      send_item(mwia_pkg::OP_SUB, 64'h0, 64'h1);
      send_item(mwia_pkg::OP_MUL, 64'h80, 64'hFF);
      send_item(mwia_pkg::OP_DIV, 64'h80, 64'hFF);
      send_item(mwia_pkg::OP_DIV, 64'hF9, 64'h2);
      send_item(mwia_pkg::OP_DIV, 64'h12, 64'h100);
      send_item(mwia_pkg::OP_MOD, 64'hF9, 64'h2);
      send_item(mwia_pkg::OP_MOD, 64'h80, 64'hFF);
      send_item(mwia_pkg::OP_MOD, 64'h5, 64'h0);
      send_item(mwia_pkg::OP_AND, 64'hA5, 64'h3C);
      send_item(mwia_pkg::OP_OR, 64'hA5, 64'h3C);
      send_item(mwia_pkg::OP_SHL, 64'h81, 64'h7);
      send_item(mwia_pkg::OP_SHL, 64'h81, 64'h8);
      send_item(mwia_pkg::OP_SHR, 64'h80, 64'h3);
      send_item(mwia_pkg::OP_SHR, 64'h80, 64'hC8);
      send_item(mwia_pkg::OP_SHR, 64'h40, 64'hC8);
      send_item(4'd9, 64'h12, 64'h34);
      send_item(4'd15, {64{1'b1}}, {64{1'b1}});
      drain_results();

      // Directed: unsigned 64-bit corners
      set_mode(1'b0, mwia_pkg::WSEL_64);
      send_item(mwia_pkg::OP_ADD, {64{1'b1}}, 64'h1);
      send_item(mwia_pkg::OP_MUL, {64{1'b1}}, {64{1'b1}});
      send_item(mwia_pkg::OP_DIV, {64{1'b1}}, 64'h3);
      send_item(mwia_pkg::OP_SHR, 64'h8000_0000_0000_0000, 64'd63);
      send_item(mwia_pkg::OP_SHL, 64'h1, 64'd64);
      drain_results();

      // Random: every mode, idling pattern changes across the run
      for (cfg = 0; cfg < 8; cfg++) begin
         if (cfg < 3) begin
            send_idle_pct = 21;
            recv_idle_pct = 79;
         end else if (cfg < 6) begin
            send_idle_pct = 79;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_mode(cfg[0], 2'(cfg + (cfg >> 2)));
         for (int n = 0; n < 75; n++) begin
            if (cfg == 7 && n == 5) hold_request = 1'b1;
            op = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                          : 4'($urandom_range(8));
            send_item(op, pick_operand(), pick_operand());
         end
         drain_results();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("multi_width_integer_alu test passed");
      end else begin
         $display("multi_width_integer_alu test failed");
      end
      $finish;
   end

endmodule
